### rtl/tmbm_pkg.sv
// Package for the temporal median background mask unit.
// Holds widths, reset values, the controller states and the command/status bundles.
// No dependencies.
package tmbm_pkg;

   localparam int FRAMES_DEFAULT = 16;
   localparam int SAMPLE_W = 8;
   localparam int BIT_IDX_W = 3;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_EMIT_RD,
      ST_EMIT_LD
   } tmbm_state_type;

   typedef struct packed {
      logic load;
      logic init_scan;
      logic scan_issue;
      logic commit;
      logic emit_read;
      logic emit_load;
      logic clear_series;
   } tmbm_cmd_type;

   typedef struct packed {
      logic addr_last;
      logic bit_zero;
      logic out_free;
   } tmbm_status_type;

endpackage

### rtl/tmbm_if.sv
// Channel interfaces for the temporal median background mask unit.
// Depends on tmbm_pkg for the sample width.
interface tmbm_req_if;
   logic                          valid;
   logic                          ready;
   logic [tmbm_pkg::SAMPLE_W-1:0] pixel_sample;
   logic                          series_end;

   modport source (output valid, output pixel_sample, output series_end, input ready);
   modport sink (input valid, input pixel_sample, input series_end, output ready);
endinterface

interface tmbm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmbm_pkg::SAMPLE_W-1:0] masked_sample;
   logic                          final_result;
   logic                          overflow;

   modport source (output valid, output masked_sample, output final_result,
                   output overflow, input ready);
   modport sink (input valid, input masked_sample, input final_result,
                 input overflow, output ready);
endinterface

interface tmbm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tmbm_pkg::SAMPLE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/temporal_median_background_mask_unit.sv
// Temporal median background mask unit: top level.
// Operation: a series of n stored samples loads at one transfer per cycle, then goes
// through rank selection (eight bit passes over the single store read port), then emits
// its results one at a time, each a store read and a result load that waits for a free output.
// Reset (synchronous, active high) empties the series and sets the threshold to 10.
module temporal_median_background_mask_unit #(
   parameter int FRAMES = tmbm_pkg::FRAMES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tmbm_req_if.sink   req_bus,
   tmbm_rsp_if.source rsp_bus,
   tmbm_csr_if.sink   csr_bus
);

   tmbm_pkg::tmbm_cmd_type    cmd;
   tmbm_pkg::tmbm_status_type status;
   logic                      req_ready;

   assign req_bus.ready = req_ready;

   tmbm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_series_end (req_bus.series_end),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   tmbm_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_bus.pixel_sample),
      .cmd        (cmd),
      .status     (status),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule

### rtl/tmbm_ctrl.sv
// Controller state machine: load, radix rank selection passes, and emission.
// Depends on tmbm_pkg for states, commands and status.
module tmbm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_series_end,
   output logic                      req_ready,
   input  tmbm_pkg::tmbm_status_type status,
   output tmbm_pkg::tmbm_cmd_type    cmd
);

   tmbm_pkg::tmbm_state_type state_ff;
   tmbm_pkg::tmbm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmbm_pkg::ST_IDLE: begin
            if (req_valid && req_series_end) state_in = tmbm_pkg::ST_START;
         end
         tmbm_pkg::ST_START: state_in = tmbm_pkg::ST_SCAN;
         tmbm_pkg::ST_SCAN: begin
            if (status.addr_last) state_in = tmbm_pkg::ST_DRAIN;
         end
         tmbm_pkg::ST_DRAIN: state_in = tmbm_pkg::ST_COMMIT;
         tmbm_pkg::ST_COMMIT: begin
            state_in = status.bit_zero ? tmbm_pkg::ST_EMIT_RD : tmbm_pkg::ST_SCAN;
         end
         tmbm_pkg::ST_EMIT_RD: state_in = tmbm_pkg::ST_EMIT_LD;
         tmbm_pkg::ST_EMIT_LD: begin
            if (status.out_free) begin
               state_in = status.addr_last ? tmbm_pkg::ST_IDLE : tmbm_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = tmbm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         tmbm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tmbm_pkg::ST_START:   cmd.init_scan = 1'b1;
         tmbm_pkg::ST_SCAN:    cmd.scan_issue = 1'b1;
         tmbm_pkg::ST_DRAIN:   cmd = '0;
         tmbm_pkg::ST_COMMIT:  cmd.commit = 1'b1;
         tmbm_pkg::ST_EMIT_RD: cmd.emit_read = 1'b1;
         tmbm_pkg::ST_EMIT_LD: begin
            cmd.emit_load    = status.out_free;
            cmd.clear_series = status.out_free && status.addr_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/tmbm_datapath.sv
// Datapath: sample store, radix select of the two middle ranks, masking and result register.
// Depends on tmbm_pkg and the channel interfaces in tmbm_if.
module tmbm_datapath #(
   parameter int FRAMES = tmbm_pkg::FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tmbm_pkg::SAMPLE_W-1:0] req_sample,
   input  tmbm_pkg::tmbm_cmd_type        cmd,
   output tmbm_pkg::tmbm_status_type     status,
   tmbm_csr_if.sink                      csr_bus,
   tmbm_rsp_if.source                    rsp_bus
);

   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int SW    = tmbm_pkg::SAMPLE_W;
   localparam int BW    = tmbm_pkg::BIT_IDX_W;

   logic [SW-1:0] store_mem [FRAMES];

   logic [SW-1:0]    threshold_ff;
   logic [CNT_W-1:0] count_ff;
   logic             overflow_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [SW-1:0]    rd_data_ff;
   logic             acc_valid_ff;
   logic [BW-1:0]    bit_ff;
   logic [SW-1:0]    lo_prefix_ff, hi_prefix_ff;
   logic [CNT_W-1:0] lo_rank_ff, hi_rank_ff;
   logic [CNT_W-1:0] lo_cnt_ff, hi_cnt_ff;
   logic [SW-1:0]    median_ff;
   logic             rsp_valid_ff;
   logic [SW-1:0]    rsp_sample_ff;
   logic             rsp_final_ff;
   logic             rsp_ovf_ff;

   logic             store_full;
   logic [CNT_W-1:0] last_idx;
   logic [SW-1:0]    hi_mask;
   logic [SW-1:0]    bit_mask;
   logic             lo_match, hi_match;
   logic [SW-1:0]    lo_prefix_in, hi_prefix_in;
   logic [CNT_W-1:0] lo_rank_in, hi_rank_in;
   logic [SW:0]      median_sum;
   logic [SW-1:0]    diff;
   logic [SW-1:0]    masked;

   assign store_full = (count_ff >= CNT_W'(FRAMES));
   assign last_idx   = count_ff - CNT_W'(1);
   assign csr_bus.ready = 1'b1;

   assign status.addr_last = (CNT_W'(addr_ff) == last_idx);
   assign status.bit_zero  = (bit_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_bus.ready;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tmbm_pkg::THRESHOLD_RESET;
      end else if (csr_bus.valid) begin
         threshold_ff <= csr_bus.data;
      end
   end

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && !store_full) begin
         store_mem[count_ff[IDX_W-1:0]] <= req_sample;
      end
      if (cmd.scan_issue || cmd.emit_read) begin
         rd_data_ff <= store_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.clear_series) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.load) begin
         if (store_full) begin
            overflow_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // samples that agree with the prefix above the current bit and have a zero there
   assign hi_mask  = SW'({SW{1'b1}} << ({1'b0, bit_ff} + (BW + 1)'(1)));
   assign bit_mask = SW'(1) << bit_ff;
   assign lo_match = (((rd_data_ff ^ lo_prefix_ff) & hi_mask) == '0)
                     && ((rd_data_ff & bit_mask) == '0);
   assign hi_match = (((rd_data_ff ^ hi_prefix_ff) & hi_mask) == '0)
                     && ((rd_data_ff & bit_mask) == '0);

   // decide the current bit of each rank from the count of smaller candidates
   always_comb begin
      lo_prefix_in = lo_prefix_ff;
      lo_rank_in   = lo_rank_ff;
      hi_prefix_in = hi_prefix_ff;
      hi_rank_in   = hi_rank_ff;
      if (lo_rank_ff >= lo_cnt_ff) begin
         lo_prefix_in = lo_prefix_ff | bit_mask;
         lo_rank_in   = lo_rank_ff - lo_cnt_ff;
      end
      if (hi_rank_ff >= hi_cnt_ff) begin
         hi_prefix_in = hi_prefix_ff | bit_mask;
         hi_rank_in   = hi_rank_ff - hi_cnt_ff;
      end
   end

   assign median_sum = {1'b0, lo_prefix_in} + {1'b0, hi_prefix_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         acc_valid_ff <= cmd.scan_issue;
         if (cmd.init_scan || cmd.commit) begin
            addr_ff <= '0;
         end else if (cmd.scan_issue || cmd.emit_load) begin
            addr_ff <= addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_scan) begin
         bit_ff       <= '1;
         lo_prefix_ff <= '0;
         hi_prefix_ff <= '0;
         lo_rank_ff   <= last_idx >> 1;
         hi_rank_ff   <= count_ff >> 1;
         lo_cnt_ff    <= '0;
         hi_cnt_ff    <= '0;
      end else if (cmd.commit) begin
         bit_ff       <= bit_ff - BW'(1);
         lo_prefix_ff <= lo_prefix_in;
         hi_prefix_ff <= hi_prefix_in;
         lo_rank_ff   <= lo_rank_in;
         hi_rank_ff   <= hi_rank_in;
         lo_cnt_ff    <= '0;
         hi_cnt_ff    <= '0;
         median_ff    <= median_sum[SW:1];
      end else if (acc_valid_ff) begin
         lo_cnt_ff <= lo_cnt_ff + CNT_W'(lo_match);
         hi_cnt_ff <= hi_cnt_ff + CNT_W'(hi_match);
      end
   end

   // zero a nonzero sample that lies within the threshold of the median
   assign diff   = (rd_data_ff > median_ff) ? (rd_data_ff - median_ff)
                                             : (median_ff - rd_data_ff);
   assign masked = ((rd_data_ff != '0) && (diff < threshold_ff)) ? '0 : rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_sample_ff <= masked;
         rsp_final_ff  <= status.addr_last;
         rsp_ovf_ff    <= overflow_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.masked_sample = rsp_sample_ff;
   assign rsp_bus.final_result  = rsp_final_ff;
   assign rsp_bus.overflow      = rsp_ovf_ff;

endmodule

### dv/tmbm_mask_checker.sv
`timescale 1ns / 1ps
// Checker for the temporal median background mask unit: watches the request, result and
// threshold write channels, predicts the masked series and compares every result transfer.
// Depends on tmbm_pkg for widths and the threshold reset value.
module tmbm_mask_checker #(
   parameter int FRAMES = tmbm_pkg::FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [tmbm_pkg::SAMPLE_W-1:0] req_pixel_sample,
   input  logic                          req_series_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tmbm_pkg::SAMPLE_W-1:0] rsp_masked_sample,
   input  logic                          rsp_final_result,
   input  logic                          rsp_overflow,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tmbm_pkg::SAMPLE_W-1:0] csr_data,
   output int                            mismatches,
   output int                            results_due
);

   typedef struct packed {
      logic [tmbm_pkg::SAMPLE_W-1:0] masked_sample;
      logic                          final_result;
      logic                          overflow;
   } mask_result_type;

   logic [tmbm_pkg::SAMPLE_W-1:0] series_samples [FRAMES];
   int unsigned                   series_len;
   logic                          dropped_seen;
   logic [tmbm_pkg::SAMPLE_W-1:0] near_threshold;
   mask_result_type               expected_masks [$];

   function automatic logic [tmbm_pkg::SAMPLE_W-1:0] median_of_series(input int unsigned n);
      logic [tmbm_pkg::SAMPLE_W-1:0] sorted [FRAMES];
      logic [tmbm_pkg::SAMPLE_W-1:0] key;
      logic [tmbm_pkg::SAMPLE_W:0]   pair_sum;
      int                            j;
      for (int i = 0; i < n; i++) sorted[i] = series_samples[i];
      for (int i = 1; i < n; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      if (n % 2 == 1) return sorted[n/2];
      // even count: floored mean of the two middle values
      pair_sum = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]};
      return pair_sum[tmbm_pkg::SAMPLE_W:1];
   endfunction

   task automatic predict_sample(input logic [tmbm_pkg::SAMPLE_W-1:0] pixel, input logic last);
      logic [tmbm_pkg::SAMPLE_W-1:0] median;
      logic [tmbm_pkg::SAMPLE_W-1:0] sample;
      logic [tmbm_pkg::SAMPLE_W-1:0] diff;
      mask_result_type               r;
      if (series_len < FRAMES) begin
         series_samples[series_len] = pixel;
         series_len++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (last) begin
         median = median_of_series(series_len);
         for (int k = 0; k < series_len; k++) begin
            sample = series_samples[k];
            diff = (sample > median) ? sample - median : median - sample;
            r.masked_sample = (sample != 0 && diff < near_threshold) ? '0 : sample;
            r.final_result = (k == series_len - 1);
            r.overflow = dropped_seen;
            expected_masks = {expected_masks, r};
         end
         series_len = 0;
         dropped_seen = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns checker: %s got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      mask_result_type want;
      if (reset) begin
         near_threshold = tmbm_pkg::THRESHOLD_RESET;
         series_len = 0;
         dropped_seen = 1'b0;
         expected_masks.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_masks.size() == 0) begin
               report_mismatch("result with nothing due, masked_sample", rsp_masked_sample, -1);
            end else begin
               want = expected_masks.pop_front();
               if (rsp_masked_sample !== want.masked_sample)
                  report_mismatch("masked_sample", rsp_masked_sample, want.masked_sample);
               if (rsp_final_result !== want.final_result)
                  report_mismatch("final_result", rsp_final_result, want.final_result);
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", rsp_overflow, want.overflow);
            end
         end
         if (csr_valid && csr_ready) near_threshold = csr_data;
         if (req_valid && req_ready) predict_sample(req_pixel_sample, req_series_end);
      end
      results_due = expected_masks.size();
   end

endmodule

### dv/temporal_median_background_mask_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the temporal median background mask unit: drives pixel series and
// threshold writes with random idling and stalls, and gives the verdict from the checker.
// Depends on tmbm_pkg, the channel interfaces, the unit and tmbm_mask_checker.
module temporal_median_background_mask_unit_tb;

   typedef enum int {
      MIX_WIDE,
      MIX_CLUSTER,
      MIX_SPARSE
   } sample_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   results_due;
   bit   calm = 1'b0;
   bit   hold_request = 1'b0;

   tmbm_req_if req_bus ();
   tmbm_rsp_if rsp_bus ();
   tmbm_csr_if csr_bus ();

   temporal_median_background_mask_unit #(
      .FRAMES(tmbm_pkg::FRAMES_DEFAULT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   tmbm_mask_checker #(
      .FRAMES(tmbm_pkg::FRAMES_DEFAULT)
   ) mask_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_pixel_sample (req_bus.pixel_sample),
      .req_series_end   (req_bus.series_end),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_masked_sample(rsp_bus.masked_sample),
      .rsp_final_result (rsp_bus.final_result),
      .rsp_overflow     (rsp_bus.overflow),
      .csr_valid        (csr_bus.valid),
      .csr_ready        (csr_bus.ready),
      .csr_data         (csr_bus.data),
      .mismatches       (mismatches),
      .results_due      (results_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 19);
         end
      end
   end

   // one series, last sample marked; valid stays high between back-to-back transfers
   task automatic send_series(input logic [tmbm_pkg::SAMPLE_W-1:0] vals[$]);
      foreach (vals[i]) begin
         @(negedge clock);
         while (!calm && $urandom_range(99) < 19) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.pixel_sample <= vals[i];
         req_bus.series_end <= (i == vals.size() - 1);
         do @(posedge clock); while (!req_bus.ready);
      end
   endtask

   // drop the request, let every result drain, then write the threshold
   task automatic write_threshold(input logic [tmbm_pkg::SAMPLE_W-1:0] value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      repeat (20) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [tmbm_pkg::SAMPLE_W-1:0] vals [$];
      sample_mix_type                mix;
      int                            samples_sent;
      int                            phase;
      int                            len;
      int                            base;
      int                            spread;
      int                            v;
      logic [tmbm_pkg::SAMPLE_W-1:0] threshold;

      req_bus.valid = 1'b0;
      req_bus.pixel_sample = '0;
      req_bus.series_end = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // single samples at both extremes, then an even pair spanning the range
      vals = {8'd0};
      send_series(vals);
      vals = {8'd255};
      send_series(vals);
      vals = {8'd255, 8'd0};
      send_series(vals);
      vals = {8'd10, 8'd20, 8'd30};
      send_series(vals);
      vals = {8'd100, 8'd105, 8'd112, 8'd200};
      send_series(vals);
      // zero threshold masks nothing
      write_threshold(8'd0);
      vals = {8'd50, 8'd50, 8'd51};
      send_series(vals);
      write_threshold(8'd255);
      vals = {8'd0, 8'd255, 8'd1, 8'd128};
      send_series(vals);
      // differences at the threshold boundary, zero sample inside the series
      write_threshold(tmbm_pkg::THRESHOLD_RESET);
      vals = {8'd9, 8'd0, 8'd20, 8'd19, 8'd1};
      send_series(vals);

      samples_sent = 0;
      phase = 0;
      while (samples_sent < 360) begin
         if (phase % 5 == 0) threshold = ((phase / 5) % 2 == 1) ? 8'd255 : 8'd0;
         else if (phase % 5 == 1) threshold = tmbm_pkg::SAMPLE_W'($urandom_range(255));
         else threshold = tmbm_pkg::SAMPLE_W'($urandom_range(1, 32));
         write_threshold(threshold);
         calm = (phase == 2);
         if (phase == 4) hold_request = 1'b1;
         for (int s = 0; s < 6 && samples_sent < 360; s++) begin
            // most series fit the store; some run past it and overflow
            len = ($urandom_range(99) < 12) ? $urandom_range(17, 21) : $urandom_range(1, 16);
            mix = sample_mix_type'($urandom_range(2));
            base = $urandom_range(255);
            spread = $urandom_range(1, 24);
            vals.delete();
            repeat (len) begin
               case (mix)
                  MIX_WIDE: begin
                     v = $urandom_range(255);
                  end
                  MIX_CLUSTER: begin
                     v = base + $urandom_range(2 * spread) - spread;
                     if (v < 0) v = 0;
                     if (v > 255) v = 255;
                  end
                  default: begin
                     v = ($urandom_range(3) == 0) ? $urandom_range(255) : 0;
                  end
               endcase
               vals = {vals, v[tmbm_pkg::SAMPLE_W-1:0]};
            end
            send_series(vals);
            samples_sent += len;
         end
         phase++;
      end
      calm = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      repeat (250) @(negedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
